FILE: rtl/htsa_pkg.sv
// Shared types and constants of the Hermite trajectory sampler.
// Holds the request and result payloads, register indexes, op codes and
// the sequencer states. Depends on nothing.
`default_nettype none

package htsa_pkg;

	localparam int DATA_W   = 32;
	localparam int TIME_W   = 32;
	localparam int DUR_W    = 32;
	localparam int WCOUNT_W = 7;
	localparam int JCOUNT_W = 4;
	localparam int WP_W     = 6;
	localparam int JT_W     = 3;
	localparam int CFG_IDX_W = 2;

	localparam logic [DUR_W-1:0]    DURATION_RESET = 32'd65536;
	localparam logic [WCOUNT_W-1:0] WCOUNT_RESET   = 7'd0;
	localparam logic [JCOUNT_W-1:0] JCOUNT_RESET   = 4'd1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DURATION       = 2'd0,
		CFG_WAYPOINT_COUNT = 2'd1,
		CFG_JOINT_COUNT    = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef struct packed {
		logic                     op;
		logic [WP_W-1:0]          waypoint;
		logic [JT_W-1:0]          joint;
		logic signed [DATA_W-1:0] position;
		logic signed [DATA_W-1:0] velocity;
		logic [TIME_W-1:0]        time_req;
	} htsa_req_t;

	typedef struct packed {
		logic [JT_W-1:0]          joint_index;
		logic signed [DATA_W-1:0] joint_position;
		logic                     last;
	} htsa_res_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_SCALE,
		S_SCALE_W,
		S_DIV,
		S_U2,
		S_U2_W,
		S_U3,
		S_U3_W,
		S_BASIS,
		S_RD0,
		S_RD1,
		S_M0,
		S_M1,
		S_M2,
		S_M3,
		S_ACC,
		S_EMIT
	} htsa_state_t;

endpackage

`default_nettype wire

FILE: rtl/htsa_stream_if.sv
// Valid/ready stream channel used for requests and results.
// The payload type is a parameter; the payload structs live in htsa_pkg.
`default_nettype none

interface htsa_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: rtl/htsa_table.sv
// Waypoint table: position and velocity memories with one write port and
// one registered read port each. Uses DATA_W from htsa_pkg.
`default_nettype none

module htsa_table
	import htsa_pkg::*;
#(
	parameter int DEPTH  = 512,
	parameter int ADDR_W = 9
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [DATA_W-1:0] wpos,
	input  wire logic [DATA_W-1:0] wvel,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [DATA_W-1:0] rpos,
	output logic      [DATA_W-1:0] rvel
);

	logic [DATA_W-1:0] pos_mem [DEPTH];
	logic [DATA_W-1:0] vel_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			pos_mem[waddr] <= wpos;
			vel_mem[waddr] <= wvel;
		end
		rpos <= pos_mem[raddr];
		rvel <= vel_mem[raddr];
	end

endmodule

`default_nettype wire

FILE: rtl/htsa_div.sv
// Restoring divider, one quotient bit per cycle, for the segment position.
// The caller guarantees that the top DSOR_W dividend bits are below the
// divisor, so the quotient fits in HEAD_W + EXT_W bits. No package needed.
`default_nettype none

module htsa_div #(
	parameter int DSOR_W = 32,
	parameter int HEAD_W = 7,
	parameter int EXT_W  = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [DSOR_W+HEAD_W-1:0]   dividend,
	input  wire logic [DSOR_W-1:0]          divisor,
	output logic                            busy,
	output logic      [HEAD_W+EXT_W-1:0]    quotient
);

	localparam int QUOT_W = HEAD_W + EXT_W;
	localparam int CNT_W  = $clog2(QUOT_W + 1);

	logic [CNT_W-1:0]  cnt_q;
	logic [DSOR_W-1:0] rem_q;
	logic [DSOR_W-1:0] d_q;
	logic [QUOT_W-1:0] sh_q;
	logic [DSOR_W+1:0] diff;

	// The shift register feeds dividend bits in at the top and collects
	// quotient bits at the bottom.
	assign diff = {1'b0, rem_q, sh_q[QUOT_W-1]} - {2'b00, d_q};
	assign busy = (cnt_q != '0);
	assign quotient = sh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(QUOT_W);
		end else if (busy) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[DSOR_W+HEAD_W-1:HEAD_W];
			sh_q  <= {dividend[HEAD_W-1:0], {EXT_W{1'b0}}};
			d_q   <= divisor;
		end else if (busy) begin
			if (!diff[DSOR_W+1]) begin
				rem_q <= diff[DSOR_W-1:0];
				sh_q  <= {sh_q[QUOT_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[DSOR_W-2:0], sh_q[QUOT_W-1]};
				sh_q  <= {sh_q[QUOT_W-2:0], 1'b0};
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/htsa_mul.sv
// Shared signed multiplier with a registered product.
// Serves the time scaling, the powers of u and the Hermite products.
`default_nettype none

module htsa_mul #(
	parameter int A_W = 19,
	parameter int B_W = 33
) (
	input  wire logic                    clk,
	input  wire logic signed [A_W-1:0]   a,
	input  wire logic signed [B_W-1:0]   b,
	output logic      signed [A_W+B_W-1:0] p
);

	logic signed [A_W+B_W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

	assign p = p_q;

endmodule

`default_nettype wire

FILE: rtl/hermite_trajectory_sampler.sv
// Hermite trajectory sampler, top level.
// Depends on htsa_pkg, htsa_stream_if, htsa_table, htsa_div and htsa_mul.
//
// Usage: the request channel carries loads and queries. A load writes the
// position and velocity of one joint at one waypoint; loads outside the
// table are dropped. A query brings a time and produces one result per
// joint in joint order, the final one marked with last. With fewer than
// two waypoints or no joints a query produces nothing.
// Configuration (duration, waypoint count, joint count) is written through
// the cfg port while the block is idle.
// A query at or past the end of the trajectory skips the time scaling and
// the divide. The serial divider (one quotient bit a cycle) and the single
// shared multiplier, four products per joint, set how long a query takes.
// One request is worked on at a time; request ready is high only when idle.
// Results leave through an output register, so a stalled receiver holds the
// sequencer on the pending result while the next request can already be
// taken once the final result is registered. Reset returns the sequencer to
// idle, clears the output valid flag and sets the configuration to its reset
// values; table contents are undefined until loaded.
`default_nettype none

module hermite_trajectory_sampler
	import htsa_pkg::*;
#(
	parameter int MAX_WAYPOINTS = 64,
	parameter int MAX_JOINTS    = 8,
	parameter int FRAC_BITS     = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [DATA_W-1:0]    cfg_data,
	htsa_stream_if.sink               request,
	htsa_stream_if.source             result
);

	localparam int CW    = WCOUNT_W;
	localparam int SW    = TIME_W + CW;
	localparam int QW    = CW + FRAC_BITS;
	localparam int UW    = FRAC_BITS + 1;
	localparam int HW    = FRAC_BITS + 3;
	localparam int BW    = DATA_W + 1;
	localparam int PW    = HW + BW;
	localparam int ACCW  = PW + 2;
	localparam int RW    = ACCW - FRAC_BITS;
	localparam int DEPTH = MAX_WAYPOINTS * MAX_JOINTS;
	localparam int ADW   = $clog2(DEPTH);
	localparam int NJW   = $clog2(MAX_JOINTS + 1);

	localparam logic [UW-1:0] U_ONE = UW'(1) << FRAC_BITS;
	localparam logic signed [ACCW-1:0] ACC_HALF = ACCW'(1) << (FRAC_BITS - 1);

	htsa_state_t state_q, state_d;

	logic [DUR_W-1:0]    duration_q;
	logic [WCOUNT_W-1:0] wcount_q;
	logic [JCOUNT_W-1:0] jcount_q;

	logic [TIME_W-1:0] tq_q;
	logic [CW-1:0]     n_q;
	logic [NJW-1:0]    nj_q;
	logic [NJW-1:0]    j_q;
	logic [CW-1:0]     seg_q;
	logic [UW-1:0]     u_q, u2_q, u3_q;
	logic signed [HW-1:0] h00_q, h10_q, h01_q, h11_q;
	logic [ADW-1:0]    base_q;
	logic signed [DATA_W-1:0] p0_q, v0_q, p1_q, v1_q;
	logic signed [ACCW-1:0]   acc_q;
	logic      out_valid_q;
	htsa_res_t out_q;

	logic signed [HW-1:0] mul_a;
	logic signed [BW-1:0] mul_b;
	logic signed [PW-1:0] mul_p;
	logic signed [ACCW-1:0] mul_ext;

	logic            div_start;
	logic            div_busy;
	logic [QW-1:0]   div_quot;

	logic              tbl_we;
	logic [ADW-1:0]    tbl_waddr;
	logic [ADW-1:0]    tbl_raddr;
	logic [DATA_W-1:0] tbl_rpos, tbl_rvel;

	logic           req_fire;
	logic           is_query;
	logic [CW-1:0]  n_clamp;
	logic [NJW-1:0] nj_clamp;
	logic           q_empty;
	logic           q_at_end;
	logic           out_free;
	logic           last_joint;
	logic [ADW-1:0] addr0;

	logic signed [HW-1:0] su, su2, su3, s_one;
	logic signed [HW-1:0] h00_d, h10_d, h01_d, h11_d;
	logic signed [RW-1:0] r_round;
	logic [DATA_W-1:0]    r_sat;

	// ---------------------------------------------------------------
	// Request decode
	// ---------------------------------------------------------------
	assign req_fire = request.valid && request.ready;
	assign is_query = (request.payload.op == OP_QUERY);
	assign n_clamp  = (int'(wcount_q) > MAX_WAYPOINTS) ? CW'(MAX_WAYPOINTS) : wcount_q;
	assign nj_clamp = (int'(jcount_q) > MAX_JOINTS) ? NJW'(MAX_JOINTS) : NJW'(jcount_q);
	assign q_empty  = (n_clamp < CW'(2)) || (nj_clamp == '0);
	// tq * (n-1) / d reaches n-1 exactly when tq >= d.
	assign q_at_end = (duration_q == '0) || (request.payload.time_req >= duration_q);

	assign tbl_we = req_fire && (request.payload.op == OP_LOAD)
		&& (int'(request.payload.waypoint) < MAX_WAYPOINTS)
		&& (int'(request.payload.joint) < MAX_JOINTS);
	assign tbl_waddr = ADW'(int'(request.payload.waypoint) * MAX_JOINTS
		+ int'(request.payload.joint));

	assign out_free   = !out_valid_q || result.ready;
	assign last_joint = ((j_q + NJW'(1)) == nj_q);
	assign addr0      = base_q + ADW'(j_q);

	// ---------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duration_q <= DURATION_RESET;
			wcount_q   <= WCOUNT_RESET;
			jcount_q   <= JCOUNT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DURATION:       duration_q <= cfg_data;
				CFG_WAYPOINT_COUNT: wcount_q   <= cfg_data[WCOUNT_W-1:0];
				CFG_JOINT_COUNT:    jcount_q   <= cfg_data[JCOUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Sequencer
	// ---------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_fire && is_query && !q_empty) begin
					state_d = q_at_end ? S_U2 : S_SCALE;
				end
			end
			S_SCALE:   state_d = S_SCALE_W;
			S_SCALE_W: state_d = S_DIV;
			S_DIV: begin
				if (!div_busy) begin
					state_d = S_U2;
				end
			end
			S_U2:    state_d = S_U2_W;
			S_U2_W:  state_d = S_U3;
			S_U3:    state_d = S_U3_W;
			S_U3_W:  state_d = S_BASIS;
			S_BASIS: state_d = S_RD0;
			S_RD0:   state_d = S_RD1;
			S_RD1:   state_d = S_M0;
			S_M0:    state_d = S_M1;
			S_M1:    state_d = S_M2;
			S_M2:    state_d = S_M3;
			S_M3:    state_d = S_ACC;
			S_ACC:   state_d = S_EMIT;
			S_EMIT: begin
				if (out_free) begin
					state_d = last_joint ? S_IDLE : S_RD0;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		request.ready = 1'b0;
		div_start     = 1'b0;
		mul_a         = '0;
		mul_b         = '0;
		tbl_raddr     = addr0;
		case (state_q)
			S_IDLE:  request.ready = 1'b1;
			S_SCALE: begin
				mul_a = $signed(HW'(n_q - CW'(1)));
				mul_b = $signed({1'b0, tq_q});
			end
			S_SCALE_W: div_start = 1'b1;
			S_U2: begin
				mul_a = $signed(HW'(u_q));
				mul_b = $signed(BW'(u_q));
			end
			S_U3: begin
				mul_a = $signed(HW'(u2_q));
				mul_b = $signed(BW'(u_q));
			end
			S_RD1: tbl_raddr = addr0 + ADW'(MAX_JOINTS);
			S_M0: begin
				mul_a = h00_q;
				mul_b = $signed({p0_q[DATA_W-1], p0_q});
			end
			S_M1: begin
				mul_a = h10_q;
				mul_b = $signed({v0_q[DATA_W-1], v0_q});
			end
			S_M2: begin
				mul_a = h01_q;
				mul_b = $signed({p1_q[DATA_W-1], p1_q});
			end
			S_M3: begin
				mul_a = h11_q;
				mul_b = $signed({v1_q[DATA_W-1], v1_q});
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ---------------------------------------------------------------
	// Basis weights and result rounding
	// ---------------------------------------------------------------
	assign su    = $signed({2'b00, u_q});
	assign su2   = $signed({2'b00, u2_q});
	assign su3   = $signed({2'b00, u3_q});
	assign s_one = $signed({2'b00, U_ONE});

	assign h00_d = (su3 <<< 1) - ((su2 <<< 1) + su2) + s_one;
	assign h10_d = su3 - (su2 <<< 1) + su;
	assign h01_d = ((su2 <<< 1) + su2) - (su3 <<< 1);
	assign h11_d = su3 - su2;

	assign mul_ext = $signed({{2{mul_p[PW-1]}}, mul_p});

	// The rounding half is folded in with the first product, so only the
	// shift and the saturation remain here.
	assign r_round = RW'(acc_q >>> FRAC_BITS);

	always_comb begin
		r_sat = r_round[DATA_W-1:0];
		if (!r_round[RW-1] && (|r_round[RW-2:DATA_W-1])) begin
			r_sat = {1'b0, {(DATA_W-1){1'b1}}};
		end else if (r_round[RW-1] && !(&r_round[RW-2:DATA_W-1])) begin
			r_sat = {1'b1, {(DATA_W-1){1'b0}}};
		end
	end

	// ---------------------------------------------------------------
	// Datapath registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (req_fire && is_query) begin
					tq_q  <= request.payload.time_req;
					n_q   <= n_clamp;
					nj_q  <= nj_clamp;
					seg_q <= n_clamp - CW'(2);
					u_q   <= U_ONE;
				end
			end
			S_DIV: begin
				if (!div_busy) begin
					seg_q <= div_quot[QW-1:FRAC_BITS];
					u_q   <= {1'b0, div_quot[FRAC_BITS-1:0]};
				end
			end
			S_U2_W: u2_q <= mul_p[FRAC_BITS +: UW];
			S_U3_W: u3_q <= mul_p[FRAC_BITS +: UW];
			S_BASIS: begin
				h00_q  <= h00_d;
				h10_q  <= h10_d;
				h01_q  <= h01_d;
				h11_q  <= h11_d;
				base_q <= ADW'(int'(seg_q) * MAX_JOINTS);
				j_q    <= '0;
			end
			S_RD1: begin
				p0_q <= $signed(tbl_rpos);
				v0_q <= $signed(tbl_rvel);
			end
			S_M0: begin
				p1_q <= $signed(tbl_rpos);
				v1_q <= $signed(tbl_rvel);
			end
			S_M1: acc_q <= mul_ext + ACC_HALF;
			S_M2, S_M3, S_ACC: acc_q <= acc_q + mul_ext;
			S_EMIT: begin
				if (out_free) begin
					j_q                  <= j_q + NJW'(1);
					out_q.joint_index    <= JT_W'(j_q);
					out_q.joint_position <= $signed(r_sat);
					out_q.last           <= last_joint;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_EMIT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result.valid   = out_valid_q;
	assign result.payload = out_q;

	// ---------------------------------------------------------------
	// Units
	// ---------------------------------------------------------------
	htsa_table #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADW)
	) u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wpos  (request.payload.position),
		.wvel  (request.payload.velocity),
		.raddr (tbl_raddr),
		.rpos  (tbl_rpos),
		.rvel  (tbl_rvel)
	);

	htsa_div #(
		.DSOR_W (DUR_W),
		.HEAD_W (CW),
		.EXT_W  (FRAC_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mul_p[SW-1:0]),
		.divisor  (duration_q),
		.busy     (div_busy),
		.quotient (div_quot)
	);

	htsa_mul #(
		.A_W (HW),
		.B_W (BW)
	) u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> (state_q == S_DIV))
		else $error("divider busy outside the divide step");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) |-> (j_q < nj_q))
		else $error("joint counter past the joint count");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_BASIS) |-> ((u_q <= U_ONE) && (u2_q <= u_q) && (u3_q <= u2_q)))
		else $error("powers of u out of order");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_EMIT))
		else $error("result raised outside the emit step");

endmodule

`default_nettype wire

FILE: bench/htsa_sample_checker.sv
// Checker for the Hermite trajectory sampler: predicts the joint samples of each query.
// It mirrors the waypoint table and the configuration registers.
// Depends on htsa_pkg only.
module htsa_sample_checker
	import htsa_pkg::*;
#(
	parameter int MAX_WAYPOINTS = 64,
	parameter int MAX_JOINTS    = 8,
	parameter int FRAC_BITS     = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]    cfg_data,
	input  logic                 req_valid,
	input  logic                 req_ready,
	input  htsa_req_t            req_payload,
	input  logic                 res_valid,
	input  logic                 res_ready,
	input  htsa_res_t            res_payload,
	output int                   mismatches,
	output int                   pending
);

	localparam int DEPTH        = MAX_WAYPOINTS * MAX_JOINTS;
	localparam int REPORT_LIMIT = 10;
	localparam longint ONE       = longint'(1) << FRAC_BITS;
	localparam longint HALF      = ONE / 2;
	localparam longint POS_CEIL  = 64'sd2147483647;
	localparam longint POS_FLOOR = -64'sd2147483648;

	logic signed [DATA_W-1:0] position_mem [DEPTH];
	logic signed [DATA_W-1:0] velocity_mem [DEPTH];
	logic [DUR_W-1:0]         duration_q;
	logic [WCOUNT_W-1:0]      wcount_q;
	logic [JCOUNT_W-1:0]      jcount_q;
	htsa_res_t                expected_samples [$];

	// Queues one sample per joint at t_req; none with under two waypoints or no joints.
	function automatic void predict_samples(input logic [TIME_W-1:0] t_req);
		int n, nj, seg, a0, a1;
		longint unsigned scaled, quot, rem, u, u2, u3;
		longint h00, h10, h01, h11, acc, rounded;
		htsa_res_t sample;
		n = (wcount_q > MAX_WAYPOINTS) ? MAX_WAYPOINTS : int'(wcount_q);
		nj = (jcount_q > MAX_JOINTS) ? MAX_JOINTS : int'(jcount_q);
		if (n < 2 || nj == 0)
			return;
		// A zero duration and any time at or past the end both land on the
		// end of the last segment.
		seg = n - 2;
		u = ONE;
		if (duration_q != 0) begin
			scaled = {32'd0, t_req} * longint'(n - 1);
			quot = scaled / duration_q;
			if (quot < longint'(n - 1)) begin
				rem = scaled - quot * duration_q;
				seg = int'(quot);
				u = (rem << FRAC_BITS) / duration_q;
			end
		end
		u2 = (u * u) >> FRAC_BITS;
		u3 = (u2 * u) >> FRAC_BITS;
		h00 = 2 * longint'(u3) - 3 * longint'(u2) + ONE;
		h10 = longint'(u3) - 2 * longint'(u2) + longint'(u);
		h01 = -2 * longint'(u3) + 3 * longint'(u2);
		h11 = longint'(u3) - longint'(u2);
		for (int j = 0; j < nj; j++) begin
			a0 = seg * MAX_JOINTS + j;
			a1 = a0 + MAX_JOINTS;
			acc = h00 * longint'(position_mem[a0]) + h10 * longint'(velocity_mem[a0])
				+ h01 * longint'(position_mem[a1]) + h11 * longint'(velocity_mem[a1]);
			rounded = (acc + HALF) >>> FRAC_BITS;
			if (rounded > POS_CEIL)
				rounded = POS_CEIL;
			else if (rounded < POS_FLOOR)
				rounded = POS_FLOOR;
			sample.joint_index = JT_W'(j);
			sample.joint_position = rounded[DATA_W-1:0];
			sample.last = (j == nj - 1);
			expected_samples.push_back(sample);
		end
	endfunction

	function automatic void check_sample(input htsa_res_t got);
		htsa_res_t want;
		if (expected_samples.size() == 0) begin
			mismatches = mismatches + 1;
			if (mismatches <= REPORT_LIMIT)
				$display("%0t: sample with none expected: joint %0d position %0d last %0b",
					$time, got.joint_index, $signed(got.joint_position), got.last);
			return;
		end
		want = expected_samples.pop_front();
		if (got.joint_index !== want.joint_index || got.joint_position !== want.joint_position
				|| got.last !== want.last) begin
			mismatches = mismatches + 1;
			if (mismatches <= REPORT_LIMIT)
				$display("%0t: sample mismatch: expected joint %0d position %0d last %0b, got joint %0d position %0d last %0b",
					$time, want.joint_index, $signed(want.joint_position), want.last,
					got.joint_index, $signed(got.joint_position), got.last);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duration_q = DURATION_RESET;
			wcount_q = WCOUNT_RESET;
			jcount_q = JCOUNT_RESET;
			expected_samples.delete();
			mismatches = 0;
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_DURATION: duration_q = cfg_data;
					CFG_WAYPOINT_COUNT: wcount_q = cfg_data[WCOUNT_W-1:0];
					CFG_JOINT_COUNT: jcount_q = cfg_data[JCOUNT_W-1:0];
					default: ;
				endcase
			end
			if (res_valid && res_ready)
				check_sample(res_payload);
			if (req_valid && req_ready) begin
				if (req_payload.op == OP_LOAD) begin
					if (req_payload.waypoint < MAX_WAYPOINTS && req_payload.joint < MAX_JOINTS) begin
						position_mem[int'(req_payload.waypoint) * MAX_JOINTS + int'(req_payload.joint)] =
							req_payload.position;
						velocity_mem[int'(req_payload.waypoint) * MAX_JOINTS + int'(req_payload.joint)] =
							req_payload.velocity;
					end
				end else begin
					predict_samples(req_payload.time_req);
				end
			end
			pending = expected_samples.size();
		end
	end

endmodule

FILE: bench/hermite_trajectory_sampler_tb.sv
// Top of the Hermite trajectory sampler testbench: clock, reset, requests,
// configuration writes and the result receiver. Depends on htsa_pkg,
// htsa_stream_if, the sampler itself and htsa_sample_checker.
module hermite_trajectory_sampler_tb;
	import htsa_pkg::*;

	localparam int MAX_WP        = 64;
	localparam int MAX_JT        = 8;
	localparam int SETTLE_CYCLES = 128;
	localparam int LONG_HOLD     = 250;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam logic signed [DATA_W-1:0] POS_MAX = 32'sh7fffffff;
	localparam logic signed [DATA_W-1:0] POS_MIN = 32'sh80000000;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DATA_W-1:0]    cfg_data;
	int                   mismatches;
	int                   pending;
	logic                 idle_on;
	logic                 hold_results_req;
	logic [DUR_W-1:0]     dur_set;
	int                   n_use;
	int                   nj_use;
	logic                 written [MAX_WP][MAX_JT];

	htsa_stream_if #(.payload_t(htsa_req_t)) req_ch ();
	htsa_stream_if #(.payload_t(htsa_res_t)) res_ch ();

	hermite_trajectory_sampler dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.request(req_ch),
		.result(res_ch)
	);

	htsa_sample_checker path_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req_valid(req_ch.valid),
		.req_ready(req_ch.ready),
		.req_payload(req_ch.payload),
		.res_valid(res_ch.valid),
		.res_ready(res_ch.ready),
		.res_payload(res_ch.payload),
		.mismatches(mismatches),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("Test completed with failures");
		$finish;
	end

	// Result receiver: short random stalls, plus one long hold-off on request.
	initial begin
		int stall_left;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				res_ch.ready <= 1'b0;
				stall_left--;
			end else if (hold_results_req) begin
				hold_results_req = 1'b0;
				stall_left = LONG_HOLD - 1;
				res_ch.ready <= 1'b0;
			end else if (idle_on && $urandom_range(3, 0) == 0) begin
				stall_left = $urandom_range(4, 0);
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Valid stays high from one request to the next unless a gap is drawn.
	task automatic send_request(input htsa_req_t item);
		@(negedge clk);
		if (idle_on && $urandom_range(3, 0) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(5, 1)) @(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.payload <= item;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
	endtask

	// Stops requests until every expected sample is in and the block has settled.
	task automatic quiesce();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic htsa_req_t random_item();
		htsa_req_t item;
		item.op = 1'($urandom_range(1, 0));
		item.waypoint = WP_W'($urandom_range(MAX_WP - 1, 0));
		item.joint = JT_W'($urandom_range(MAX_JT - 1, 0));
		item.position = $urandom;
		item.velocity = $urandom;
		item.time_req = $urandom;
		return item;
	endfunction

	function automatic logic signed [DATA_W-1:0] random_value();
		case ($urandom_range(9, 0))
			0: return POS_MAX;
			1: return POS_MIN;
			2, 3, 4: return $urandom;
			default: return $signed($urandom_range(32'h0200_0000, 0)) - 32'sh0100_0000;
		endcase
	endfunction

	function automatic logic [TIME_W-1:0] random_time();
		int pick;
		pick = $urandom_range(9, 0);
		if (dur_set == 0 || pick == 9)
			return $urandom;
		if (pick < 6)
			return $urandom_range(dur_set, 0);
		// Exact segment boundaries.
		if (pick < 8 && n_use >= 2)
			return TIME_W'((64'(dur_set) * $urandom_range(n_use - 1, 0)) / (n_use - 1));
		return dur_set + $urandom_range(1000, 0);
	endfunction

	task automatic send_load(input logic [WP_W-1:0] wp, input logic [JT_W-1:0] jt,
			input logic signed [DATA_W-1:0] pos, input logic signed [DATA_W-1:0] vel);
		htsa_req_t item;
		item = random_item();
		item.op = OP_LOAD;
		item.waypoint = wp;
		item.joint = jt;
		item.position = pos;
		item.velocity = vel;
		written[wp][jt] = 1'b1;
		send_request(item);
	endtask

	task automatic send_query(input logic [TIME_W-1:0] t);
		htsa_req_t item;
		item = random_item();
		item.op = OP_QUERY;
		item.time_req = t;
		send_request(item);
	endtask

	// Writes the registers once the block is idle and records what is in use.
	task automatic set_registers(input logic [DUR_W-1:0] dur, input logic [WCOUNT_W-1:0] wcnt,
			input logic [JCOUNT_W-1:0] jcnt);
		quiesce();
		write_reg(CFG_DURATION, dur);
		write_reg(CFG_WAYPOINT_COUNT, DATA_W'(wcnt));
		write_reg(CFG_JOINT_COUNT, DATA_W'(jcnt));
		dur_set = dur;
		n_use = (wcnt > MAX_WP) ? MAX_WP : int'(wcnt);
		nj_use = (jcnt > MAX_JT) ? MAX_JT : int'(jcnt);
	endtask

	// A query may read any waypoint in use for any joint in use, so all of
	// those entries are loaded before any query under new settings.
	task automatic apply_settings(input logic [DUR_W-1:0] dur, input logic [WCOUNT_W-1:0] wcnt,
			input logic [JCOUNT_W-1:0] jcnt);
		set_registers(dur, wcnt, jcnt);
		if (n_use >= 2 && nj_use > 0) begin
			for (int wp = 0; wp < n_use; wp++)
				for (int jt = 0; jt < nj_use; jt++)
					if (!written[wp][jt])
						send_load(WP_W'(wp), JT_W'(jt), random_value(), random_value());
		end
	endtask

	task automatic random_traffic(input int count);
		int kind;
		for (int k = 0; k < count; k++) begin
			kind = $urandom_range(99, 0);
			if (kind < 55)
				send_query(random_time());
			else if (kind < 90 && n_use >= 2 && nj_use > 0)
				send_load(WP_W'($urandom_range(n_use - 1, 0)),
					JT_W'($urandom_range(nj_use - 1, 0)),
					random_value(), random_value());
			else
				send_load(WP_W'($urandom_range(MAX_WP - 1, 0)),
					JT_W'($urandom_range(MAX_JT - 1, 0)),
					random_value(), random_value());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_DURATION;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.payload = '0;
		res_ch.ready = 1'b0;
		idle_on = 1'b1;
		hold_results_req = 1'b0;
		dur_set = DURATION_RESET;
		n_use = 0;
		nj_use = 1;
		for (int wp = 0; wp < MAX_WP; wp++)
			for (int jt = 0; jt < MAX_JT; jt++)
				written[wp][jt] = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// Out of reset no waypoints are in use, then only one: no samples.
		send_load('0, '0, POS_MAX, POS_MIN);
		send_query(32'd0);
		apply_settings(DURATION_RESET, 7'd1, 4'd1);
		send_query(32'd40000);

		// Two waypoints whose tangents overshoot both ends of the range.
		send_load('0, '0, POS_MAX, POS_MAX);
		send_load(WP_W'(1), '0, POS_MAX, POS_MIN);
		send_load('0, JT_W'(1), POS_MIN, POS_MIN);
		send_load(WP_W'(1), JT_W'(1), POS_MIN, POS_MAX);
		apply_settings(32'd65536, 7'd2, 4'd2);
		send_query(32'd0);
		send_query(32'd32768);
		send_query(32'd65535);
		send_query(32'd65536);
		send_query(32'hffff_ffff);

		// Zero duration, then a write to an unused register index.
		apply_settings(32'd0, 7'd2, 4'd2);
		send_query(32'd12345);
		quiesce();
		write_reg(CFG_UNUSED, $urandom);
		send_query(32'd99);

		apply_settings(32'd65536, 7'd2, 4'd0);
		send_query(32'd1000);

		// Oversized joint and waypoint counts are clamped.
		apply_settings(32'hffff_ffff, 7'd3, 4'd15);
		send_query(32'hffff_ffff);
		send_query(32'h7fff_ffff);
		send_query(32'd0);
		// These two queries land on the last segment, so only its two
		// waypoints need to be loaded.
		send_load(WP_W'(MAX_WP - 2), '0, random_value(), random_value());
		send_load(WP_W'(MAX_WP - 1), '0, random_value(), random_value());
		set_registers(32'd1000, 7'd127, 4'd1);
		send_query(32'd999);
		send_query(32'd1000);

		apply_settings(32'h0003_0000, 7'd5, 4'd8);
		random_traffic(16);
		// Hold results back while queries keep coming, so the block backs up.
		hold_results_req = 1'b1;
		repeat (6) send_query(random_time());
		random_traffic(10);
		quiesce();
		random_traffic(10);

		apply_settings($urandom_range(255, 1), 7'($urandom_range(6, 2)),
			4'($urandom_range(MAX_JT, 1)));
		random_traffic(14);

		idle_on = 1'b0;
		apply_settings($urandom, 7'($urandom_range(6, 2)), 4'($urandom_range(MAX_JT, 1)));
		random_traffic(14);

		quiesce();
		if (mismatches == 0 && pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

FILE: hermite_trajectory_sampler.f
rtl/htsa_pkg.sv
rtl/htsa_stream_if.sv
rtl/htsa_table.sv
rtl/htsa_div.sv
rtl/htsa_mul.sv
rtl/hermite_trajectory_sampler.sv
bench/htsa_sample_checker.sv
bench/hermite_trajectory_sampler_tb.sv
